// ===== src/dlsi_pkg.sv =====
// Shared types, codes and constants for the dual LED status indicator.
// No dependencies; every other file imports this package.
package dlsi_pkg;

    typedef enum logic [2:0] {
        MODE_OFF     = 3'd0,
        MODE_ON      = 3'd1,
        MODE_FLICKER = 3'd2,
        MODE_BLINK   = 3'd3,
        MODE_SINGLE  = 3'd4,
        MODE_DOUBLE  = 3'd5,
        MODE_TRIPLE  = 3'd6,
        MODE_OFF_ALT = 3'd7
    } mode_t;

    localparam logic [3:0] PHASES_PER_CYCLE = 4'd8;
    localparam logic [3:0] MID_PHASE        = 4'd4;
    localparam logic [3:0] MAX_PATTERN_CNT  = 4'd10;

    // Per-LED pattern state.
    typedef struct packed {
        logic [3:0] cnt;
        mode_t      mode;
        logic       level;
    } led_state_t;

    // Timing of the current tick within the 400 ms cycle.
    typedef struct packed {
        logic at_mid;
        logic at_end;
        logic odd;
    } tick_ctl_t;

    localparam led_state_t LED_STATE_RESET = '{cnt: 4'd0, mode: MODE_OFF, level: 1'b0};

    // Pattern counter load value when a new mode is latched.
    function automatic logic [3:0] load_value(input mode_t mode);
        logic [3:0] val;
        begin
            case (mode)
                MODE_BLINK:  val = 4'd2;
                MODE_SINGLE: val = 4'd6;
                MODE_DOUBLE: val = 4'd8;
                MODE_TRIPLE: val = 4'd10;
                default:     val = 4'd1;
            endcase
            return val;
        end
    endfunction

endpackage

// ===== src/dlsi_led.sv =====
// Next-state logic for one LED: flicker toggling and the flash pattern step.
// Depends on dlsi_pkg.
module dlsi_led (
    input  logic                is_red,
    input  dlsi_pkg::tick_ctl_t ctl,
    input  dlsi_pkg::mode_t     req,
    input  dlsi_pkg::led_state_t cur,
    output dlsi_pkg::led_state_t nxt
);
    import dlsi_pkg::*;

    logic [3:0] c;
    mode_t      mode;
    logic       lvl;
    logic [3:0] cnt_next;

    always_comb
    begin
        c        = cur.cnt;
        mode     = cur.mode;
        lvl      = cur.level;
        cnt_next = cur.cnt;

        // Flicker follows the mode that was active before this tick.
        if (cur.mode == MODE_FLICKER)
        begin
            lvl = is_red ? ~ctl.odd : ctl.odd;
        end

        if (ctl.at_mid || ctl.at_end)
        begin
            if (c == 4'd0)
            begin
                if (ctl.at_end)
                begin
                    mode = req;
                    if (is_red)
                        lvl = (req != MODE_OFF) && (req != MODE_OFF_ALT);
                    else
                        lvl = (req == MODE_ON);
                    c = load_value(req);
                end
                else
                begin
                    // An idle counter stays at zero across mid-cycle.
                    c = 4'd1;
                end
            end
            else if (c == 4'd1)
            begin
                if (cur.mode == MODE_BLINK)
                    lvl = ~is_red;
            end
            else if (c inside {4'd5, 4'd7, 4'd9})
            begin
                lvl = ~is_red;
            end
            else if (c inside {4'd6, 4'd8})
            begin
                lvl = is_red;
            end
            else if (c == 4'd4)
            begin
                if (!is_red)
                    lvl = 1'b0;
            end
            cnt_next = c - 4'd1;
        end

        nxt = '{cnt: cnt_next, mode: mode, level: lvl};
    end

endmodule

// ===== src/dlsi_step.sv =====
// One tick of the indicator: phase counter and both LED pattern updates.
// Depends on dlsi_pkg and dlsi_led.
module dlsi_step (
    input  logic [3:0]           phase,
    input  dlsi_pkg::mode_t      green_req,
    input  dlsi_pkg::mode_t      red_req,
    input  dlsi_pkg::led_state_t green_cur,
    input  dlsi_pkg::led_state_t red_cur,
    output logic [3:0]           phase_out,
    output dlsi_pkg::led_state_t green_nxt,
    output dlsi_pkg::led_state_t red_nxt
);
    import dlsi_pkg::*;

    logic [3:0] phase_dec;
    tick_ctl_t  ctl;

    always_comb
    begin
        phase_dec  = phase - 4'd1;
        ctl.odd    = phase_dec[0];
        ctl.at_mid = (phase_dec == MID_PHASE);
        ctl.at_end = (phase_dec == 4'd0);
        phase_out  = ctl.at_end ? PHASES_PER_CYCLE : phase_dec;
    end

    dlsi_led u_green (
        .is_red (1'b0),
        .ctl    (ctl),
        .req    (green_req),
        .cur    (green_cur),
        .nxt    (green_nxt)
    );

    dlsi_led u_red (
        .is_red (1'b1),
        .ctl    (ctl),
        .req    (red_req),
        .cur    (red_cur),
        .nxt    (red_nxt)
    );

endmodule

// ===== src/dual_led_status_indicator.sv =====
// Dual LED status indicator, top level: input register, tick state and result register.
// Depends on dlsi_pkg and dlsi_step.
//
// Usage:
// Each input transfer (in_valid/in_ready with green_mode, red_mode) is one 50 ms
// tick carrying the requested mode of each LED. Each tick yields exactly one
// output transfer (out_valid/out_ready with green_led, red_led) giving both LED
// levels after that tick, in order.
// A tick taken into the input register is processed by the combinational tick
// update, and its result is registered in the result register once that register
// can take it. Throughput is one tick per cycle while the receiver does not stall;
// the input register and the result register form a two-stage pipeline.
// When the receiver stalls, the result register holds and the input register
// can still take one more tick; in_ready drops only when both are full.
// Reset sets the phase counter to one, so the first tick ends a cycle and latches
// the requested modes; both LED states start dark (the LED output registers are not reset) and both stages empty.
module dual_led_status_indicator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] green_mode,
    input  logic [2:0] red_mode,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       green_led,
    output logic       red_led
);
    import dlsi_pkg::*;

    logic       in_valid_reg;
    mode_t      green_req_reg;
    mode_t      red_req_reg;
    logic       out_valid_reg;
    logic       green_led_reg;
    logic       red_led_reg;
    logic [3:0] phase_reg;
    logic [3:0] phase_next;
    led_state_t green_reg;
    led_state_t green_next;
    led_state_t red_reg;
    led_state_t red_next;
    logic       advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign green_led = green_led_reg;
    assign red_led   = red_led_reg;

    dlsi_step u_step (
        .phase     (phase_reg),
        .green_req (green_req_reg),
        .red_req   (red_req_reg),
        .green_cur (green_reg),
        .red_cur   (red_reg),
        .phase_out (phase_next),
        .green_nxt (green_next),
        .red_nxt   (red_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 4'd1;
            green_reg     <= LED_STATE_RESET;
            red_reg       <= LED_STATE_RESET;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                phase_reg <= phase_next;
                green_reg <= green_next;
                red_reg   <= red_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            green_req_reg <= mode_t'(green_mode);
            red_req_reg   <= mode_t'(red_mode);
        end
        if (advance)
        begin
            green_led_reg <= green_next.level;
            red_led_reg   <= red_next.level;
        end
    end

    // The phase counter always runs between one and a full cycle.
    a_phase_range : assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != 4'd0) && (phase_reg <= PHASES_PER_CYCLE))
        else $error("phase counter out of range");

    // Pattern counters never exceed the longest flash sequence.
    a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
        (green_reg.cnt <= MAX_PATTERN_CNT) && (red_reg.cnt <= MAX_PATTERN_CNT))
        else $error("pattern counter out of range");

    // Tick state moves only when a tick passes into the result register.
    a_state_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_reg) && $stable(green_reg) && $stable(red_reg))
        else $error("tick state changed without a tick");

    // Whenever the result side can drain, the input must be ready to take a new tick.
    a_no_bubble : assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || out_ready) |-> in_ready)
        else $error("input stalled while the result stage could drain");

endmodule

// ===== tb/sv/led_level_checker.sv =====
`timescale 1ns / 100ps
// Checker for the dual LED status indicator: watches both channels, predicts the LED levels.
// Depends on dlsi_pkg; the test top instantiates it beside the block.
module led_level_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [2:0] green_mode,
    input  logic [2:0] red_mode,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       green_led,
    input  logic       red_led,
    output int         mismatches,
    output int         outstanding
);
    import dlsi_pkg::*;

    typedef struct packed {
        logic green;
        logic red;
    } led_pair_t;

    led_pair_t  levels_due[$];
    logic [3:0] phase;
    led_state_t green_track;
    led_state_t red_track;

    function automatic logic [3:0] flash_reload(input mode_t req);
        logic [3:0] n;
        case (req)
            MODE_BLINK:  n = 4'd2;
            MODE_SINGLE: n = 4'd6;
            MODE_DOUBLE: n = 4'd8;
            MODE_TRIPLE: n = 4'd10;
            default:     n = 4'd1;
        endcase
        return n;
    endfunction

    // One step of a LED pattern counter. Red inverts the flash steps at counts 1 and 5 to 9.
    function automatic led_state_t pattern_update(input led_state_t s, input logic is_red,
                                                  input logic at_end, input mode_t req);
        led_state_t n;
        logic [3:0] c;
        n = s;
        c = s.cnt;
        case (c)
            4'd0:
            begin
                if (!at_end)
                begin
                    c = 4'd1;
                end
                else
                begin
                    n.mode = req;
                    if (is_red)
                        n.level = (req != MODE_OFF) && (req != MODE_OFF_ALT);
                    else
                        n.level = (req == MODE_ON);
                    c = flash_reload(req);
                end
            end
            4'd1:
            begin
                if (s.mode == MODE_BLINK)
                    n.level = !is_red;
            end
            4'd5, 4'd7, 4'd9: n.level = !is_red;
            4'd6, 4'd8:       n.level = is_red;
            4'd4:
            begin
                if (!is_red)
                    n.level = 1'b0;
            end
            default: ;
        endcase
        n.cnt = c - 4'd1;
        return n;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        led_pair_t  want;
        logic       odd;
        if (!rst_n)
        begin
            phase       = 4'd1;
            green_track = LED_STATE_RESET;
            red_track   = LED_STATE_RESET;
            levels_due.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (levels_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result transfer with none expected: green %0b red %0b",
                                 $realtime, green_led, red_led);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = levels_due.pop_front();
                    if (want.green !== green_led || want.red !== red_led)
                    begin
                        if (mismatches < 10)
                            $display("%0t: expected green %0b red %0b, got green %0b red %0b",
                                     $realtime, want.green, want.red, green_led, red_led);
                        mismatches <= mismatches + 1;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                phase = phase - 4'd1;
                odd = phase[0];
                // Flicker runs off the phase parity, green and red in opposite sense.
                if (green_track.mode == MODE_FLICKER)
                    green_track.level = odd;
                if (red_track.mode == MODE_FLICKER)
                    red_track.level = !odd;
                if (phase == MID_PHASE)
                begin
                    green_track = pattern_update(green_track, 1'b0, 1'b0, mode_t'(green_mode));
                    red_track   = pattern_update(red_track, 1'b1, 1'b0, mode_t'(red_mode));
                end
                else if (phase == 4'd0)
                begin
                    green_track = pattern_update(green_track, 1'b0, 1'b1, mode_t'(green_mode));
                    red_track   = pattern_update(red_track, 1'b1, 1'b1, mode_t'(red_mode));
                    phase = PHASES_PER_CYCLE;
                end
                want.green = green_track.level;
                want.red   = red_track.level;
                levels_due.push_back(want);
            end
            outstanding <= levels_due.size();
        end
    end

endmodule

// ===== tb/sv/dual_led_status_indicator_test.sv =====
`timescale 1ns / 100ps
// Test top for the dual LED status indicator: clock, reset, tick stimulus and verdict.
// Depends on dlsi_pkg, dual_led_status_indicator and led_level_checker.
module dual_led_status_indicator_test;
    import dlsi_pkg::*;

    localparam int TICK_TARGET = 550;
    localparam int IDLE_LIMIT  = 2000;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [2:0] green_mode = 3'd0;
    logic [2:0] red_mode   = 3'd0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic       green_led;
    logic       red_led;

    int mismatches;
    int outstanding;
    int ticks_sent   = 0;
    int idle_cycles  = 0;
    int stall_left   = 0;
    int rx_span_left = 0;
    bit rx_steady    = 1'b0;
    bit tx_steady    = 1'b0;

    dual_led_status_indicator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .green_mode (green_mode),
        .red_mode   (red_mode),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .green_led  (green_led),
        .red_led    (red_led)
    );

    led_level_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .green_mode  (green_mode),
        .red_mode    (red_mode),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .green_led   (green_led),
        .red_led     (red_led),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    // Mostly short pauses, now and then a long one.
    function automatic int pause_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Receiver side: alternates between stretches of random stalls and stretches of none.
    always @(posedge clk)
    begin
        if (rx_span_left == 0)
        begin
            rx_span_left <= $urandom_range(50, 300);
            rx_steady    <= ($urandom_range(0, 3) == 0);
        end
        else
        begin
            rx_span_left <= rx_span_left - 1;
        end

        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!rx_steady && $urandom_range(0, 3) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= pause_length() - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("dual_led_status_indicator_test: FAIL");
            $finish;
        end
    end

    // Offers one tick and waits for its transfer, then maybe leaves a gap.
    task automatic send_tick(input logic [2:0] g, input logic [2:0] r);
        int gap;
        in_valid   <= 1'b1;
        green_mode <= g;
        red_mode   <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ticks_sent++;
        gap = 0;
        if (!tx_steady && $urandom_range(0, 2) == 0)
            gap = pause_length();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds off the sender until every expected LED pair has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int         kind;
        int         len;
        logic [2:0] g;
        logic [2:0] r;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every code on both LEDs, including the extremes, each held for a few ticks.
        for (int k = 0; k < 8; k++)
            repeat (3) send_tick(3'(k), 3'(7 - k));
        wait_for_results();

        while (ticks_sent < TICK_TARGET)
        begin
            kind = $urandom_range(0, 9);
            tx_steady = ($urandom_range(0, 3) == 0);
            if (kind < 7)
            begin
                // A request held for 4 to 48 ticks, which may end before the running pattern finishes and latches it.
                g = 3'($urandom_range(0, 7));
                r = 3'($urandom_range(0, 7));
                len = $urandom_range(4, 48);
                repeat (len) send_tick(g, r);
            end
            else if (kind < 9)
            begin
                len = $urandom_range(1, 12);
                repeat (len) send_tick(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            end
            else
            begin
                wait_for_results();
            end
        end

        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("dual_led_status_indicator_test: PASS");
        else
            $display("dual_led_status_indicator_test: FAIL");
        $finish;
    end

endmodule
